@@ hdl/tlce_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlce_pkg
// Shared types for the tile line cover enumerator: sequencer states and
// scan pass codes.
// ----------------------------------------------------------------------------
package tlce_pkg;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_ERR,
    ST_LINE,
    ST_WALK
  } state_t;

  // scan pass of a sloped line
  typedef enum logic {
    PASS_X_MAJOR,
    PASS_Y_MAJOR
  } pass_t;

endpackage : tlce_pkg
`default_nettype wire

@@ hdl/tlce_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlce_in_if / tlce_out_if
// Valid/ready channels of the tile line cover enumerator: line end points in,
// covered tiles out.
// ----------------------------------------------------------------------------
interface tlce_in_if #(
  parameter int COORD_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] start_x;
  logic [COORD_BITS-1:0] start_y;
  logic [COORD_BITS-1:0] end_x;
  logic [COORD_BITS-1:0] end_y;

  modport source (output valid, output start_x, output start_y, output end_x,
                  output end_y, input ready);
  modport sink (input valid, input start_x, input start_y, input end_x,
                input end_y, output ready);
endinterface : tlce_in_if

interface tlce_out_if #(
  parameter int COORD_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] tile_x;
  logic [COORD_BITS-1:0] tile_y;
  logic                  last;
  logic                  span_error;

  modport source (output valid, output tile_x, output tile_y, output last,
                  output span_error, input ready);
  modport sink (input valid, input tile_x, input tile_y, input last,
                input span_error, output ready);
endinterface : tlce_out_if
`default_nettype wire

@@ hdl/tile_line_cover_enumerator.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Flow: an accepted line is latched, set up in ST_SETUP, and then handled in ST_ERR,
//   ST_LINE or ST_WALK, which load each tile into the output register.
// One line at a time: in_ch.ready is high only in ST_IDLE. Sloped lines take one
//   error-walk step per cycle through the single error adder, except while a
//   hit waits on a blocked output register.
// Reset: synchronous, active low; clears the sequencer and the output valid.
// ----------------------------------------------------------------------------
// tile_line_cover_enumerator
// Emits the tiles covered by a line between two tile coordinates. Sloped
// lines are scanned in an x-major then a y-major pass by an integer error walk.
// ----------------------------------------------------------------------------
module tile_line_cover_enumerator
  import tlce_pkg::*;
#(
  parameter int COORD_BITS = 12,
  parameter int MAX_SPAN   = 15
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  tlce_in_if.sink     in_ch,
  tlce_out_if.source  out_ch
);

  localparam int CW     = COORD_BITS;
  localparam int SPAN_W = $clog2(MAX_SPAN + 1);
  localparam int E_W    = 2 * SPAN_W + 2;

  // control state
  state_t                  state_r, state_nxt;
  pass_t                   pass_r, pass_nxt;
  logic [SPAN_W-1:0]       i_r, i_nxt;
  logic [SPAN_W-1:0]       j_r, j_nxt;
  logic [SPAN_W-1:0]       jf_r, jf_nxt;
  logic signed [E_W-1:0]   e_r, e_nxt;
  logic signed [E_W-1:0]   ef_r, ef_nxt;
  logic                    first_r, first_nxt;

  // line registers
  logic [CW-1:0]           sx_r, sy_r, ex_r, ey_r;
  logic [SPAN_W-1:0]       adx_r, ady_r;
  logic                    stx_neg_r, sty_neg_r;
  logic                    run_y_r;
  logic [CW-1:0]           run_cur_r, run_hi_r;

  // output register
  logic                    out_valid_r;
  logic [CW-1:0]           tile_x_r, tile_y_r;
  logic                    last_r, err_r;

  // setup arithmetic
  logic signed [CW:0]      dx_s, dy_s;
  logic [CW-1:0]           adx_full, ady_full;
  logic                    too_big;

  // walk datapath
  logic [SPAN_W-1:0]       maj, minr;
  logic signed [E_W-1:0]   maj_s, two_maj, two_min;
  logic                    above, below, row_end;
  logic [SPAN_W-1:0]       jf_eff;
  logic signed [E_W-1:0]   ef_eff;
  logic signed [E_W-1:0]   add_a, add_b, e_sum;
  logic [SPAN_W-1:0]       step_x, step_y;
  logic [CW-1:0]           walk_x, walk_y;

  // emit controls
  logic                    load_ok;
  logic                    emit, emit_last, emit_err;
  logic [CW-1:0]           emit_x, emit_y;
  logic                    in_xfer;

  assign in_xfer = in_ch.valid && in_ch.ready;
  assign load_ok = !out_valid_r || out_ch.ready;

  // port drive
  assign in_ch.ready       = (state_r == ST_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.tile_x     = tile_x_r;
  assign out_ch.tile_y     = tile_y_r;
  assign out_ch.last       = last_r;
  assign out_ch.span_error = err_r;

  // span and direction of the latched line
  always_comb begin
    dx_s     = signed'({1'b0, ex_r}) - signed'({1'b0, sx_r});
    dy_s     = signed'({1'b0, ey_r}) - signed'({1'b0, sy_r});
    adx_full = dx_s[CW] ? CW'(-dx_s) : CW'(dx_s);
    ady_full = dy_s[CW] ? CW'(-dy_s) : CW'(dy_s);
    too_big  = (adx_full > CW'(MAX_SPAN)) || (ady_full > CW'(MAX_SPAN));
  end

  // major/minor spans of the current pass
  assign maj     = (pass_r == PASS_Y_MAJOR) ? ady_r : adx_r;
  assign minr    = (pass_r == PASS_Y_MAJOR) ? adx_r : ady_r;
  assign maj_s   = signed'({{(E_W - SPAN_W){1'b0}}, maj});
  assign two_maj = signed'({{(E_W - SPAN_W - 1){1'b0}}, maj, 1'b0});
  assign two_min = signed'({{(E_W - SPAN_W - 1){1'b0}}, minr, 1'b0});

  // error classification against the half-width band
  assign above   = (e_r > maj_s);
  assign below   = (e_r < -maj_s);
  assign row_end = below || (!above && (j_r == minr));
  assign jf_eff  = first_r ? j_r : jf_r;
  assign ef_eff  = first_r ? e_r : ef_r;

  // shared error adder: step along the row, or restart the next row
  assign add_a = row_end ? ef_eff : e_r;
  assign add_b = row_end ? two_min : -two_maj;
  assign e_sum = add_a + add_b;

  // tile position of the walk, stepping away from the end point
  assign step_x = (pass_r == PASS_Y_MAJOR) ? j_r : i_r;
  assign step_y = (pass_r == PASS_Y_MAJOR) ? i_r : j_r;
  assign walk_x = stx_neg_r ? (ex_r - {{(CW - SPAN_W){1'b0}}, step_x})
                            : (ex_r + {{(CW - SPAN_W){1'b0}}, step_x});
  assign walk_y = sty_neg_r ? (ey_r - {{(CW - SPAN_W){1'b0}}, step_y})
                            : (ey_r + {{(CW - SPAN_W){1'b0}}, step_y});

  // sequencer next state and emit
  always_comb begin
    state_nxt = state_r;
    pass_nxt  = pass_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    e_nxt     = e_r;
    jf_nxt    = jf_r;
    ef_nxt    = ef_r;
    first_nxt = first_r;
    emit      = 1'b0;
    emit_last = 1'b0;
    emit_err  = 1'b0;
    emit_x    = '0;
    emit_y    = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) state_nxt = ST_SETUP;
      end
      ST_SETUP: begin
        pass_nxt  = PASS_X_MAJOR;
        i_nxt     = '0;
        j_nxt     = '0;
        e_nxt     = '0;
        first_nxt = 1'b1;
        priority if (too_big) begin
          state_nxt = ST_ERR;
        end else if ((ex_r == sx_r) || (ey_r == sy_r)) begin
          state_nxt = ST_LINE;
        end else begin
          state_nxt = ST_WALK;
        end
      end
      ST_ERR: begin
        if (load_ok) begin
          emit      = 1'b1;
          emit_last = 1'b1;
          emit_err  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_LINE: begin
        if (load_ok) begin
          emit      = 1'b1;
          emit_x    = run_y_r ? ex_r : run_cur_r;
          emit_y    = run_y_r ? run_cur_r : ey_r;
          emit_last = (run_cur_r == run_hi_r);
          if (run_cur_r == run_hi_r) state_nxt = ST_IDLE;
        end
      end
      ST_WALK: begin
        priority if (above) begin
          // still short of the band: climb the minor axis
          j_nxt = j_r + SPAN_W'(1);
          e_nxt = e_sum;
        end else if (!below && !load_ok) begin
          // hit waiting on the output register
          state_nxt = state_r;
        end else begin
          if (!below) begin
            emit      = 1'b1;
            emit_x    = walk_x;
            emit_y    = walk_y;
            emit_last = (pass_r == PASS_Y_MAJOR) && (i_r == maj) && (j_r == minr);
            if (first_r) begin
              jf_nxt    = j_r;
              ef_nxt    = e_r;
              first_nxt = 1'b0;
            end
          end
          priority if (!row_end) begin
            j_nxt = j_r + SPAN_W'(1);
            e_nxt = e_sum;
          end else if (i_r == maj) begin
            if (pass_r == PASS_Y_MAJOR) begin
              state_nxt = ST_IDLE;
            end else begin
              pass_nxt  = PASS_Y_MAJOR;
              i_nxt     = '0;
              j_nxt     = '0;
              e_nxt     = '0;
              first_nxt = 1'b1;
            end
          end else begin
            // next row restarts at the first hit of this row
            i_nxt     = i_r + SPAN_W'(1);
            j_nxt     = jf_eff;
            e_nxt     = e_sum;
            first_nxt = 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pass_r  <= PASS_X_MAJOR;
      i_r     <= '0;
      j_r     <= '0;
      e_r     <= '0;
      jf_r    <= '0;
      ef_r    <= '0;
      first_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      pass_r  <= pass_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      e_r     <= e_nxt;
      jf_r    <= jf_nxt;
      ef_r    <= ef_nxt;
      first_r <= first_nxt;
    end
  end

  // line capture, setup and axis run counter
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      sx_r <= in_ch.start_x;
      sy_r <= in_ch.start_y;
      ex_r <= in_ch.end_x;
      ey_r <= in_ch.end_y;
    end
    if (state_r == ST_SETUP) begin
      adx_r     <= adx_full[SPAN_W-1:0];
      ady_r     <= ady_full[SPAN_W-1:0];
      stx_neg_r <= (ex_r > sx_r);
      sty_neg_r <= (ey_r > sy_r);
      run_y_r   <= (ex_r == sx_r);
      if (ex_r == sx_r) begin
        run_cur_r <= (sy_r < ey_r) ? sy_r : ey_r;
        run_hi_r  <= (sy_r < ey_r) ? ey_r : sy_r;
      end else begin
        run_cur_r <= (sx_r < ex_r) ? sx_r : ex_r;
        run_hi_r  <= (sx_r < ex_r) ? ex_r : sx_r;
      end
    end else if ((state_r == ST_LINE) && load_ok) begin
      run_cur_r <= run_cur_r + CW'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      tile_x_r <= emit_x;
      tile_y_r <= emit_y;
      last_r   <= emit_last;
      err_r    <= emit_err;
    end
  end

  // an error result is always the only, and so the final, result
  a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && err_r) |-> last_r)
    else $error("span error result without last");

  // walk indices stay inside the pass rectangle
  a_walk_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> ((i_r <= maj) && (j_r <= minr)))
    else $error("walk index out of range");

  // a stalled hit keeps the walk position
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_WALK) && !above && !below && !load_ok)
      |=> ($stable(i_r) && $stable(j_r) && $stable(e_r)))
    else $error("walk moved while output was blocked");

  // leaving the walk coincides with the final tile
  a_walk_ends_last: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_WALK) && (state_nxt == ST_IDLE)) |-> (emit && emit_last))
    else $error("walk finished without a last tile");

  // an accepted line is set up in the next cycle
  a_setup_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == ST_SETUP))
    else $error("accepted line not set up");

endmodule : tile_line_cover_enumerator
`default_nettype wire
